@@ rtl/owts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owts_pkg
// Shared types, codes and the command sequence table of the 1-Wire master.
// ----------------------------------------------------------------------------
package owts_pkg;

    // Low time that opens every read and write slot, in ticks
    localparam logic [9:0] START_LOW_TICKS = 10'd2;

    // Item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // Commands
    localparam logic [1:0] CMD_CONVERT   = 2'd0;
    localparam logic [1:0] CMD_READ_TEMP = 2'd1;
    localparam logic [1:0] CMD_WRITE_CFG = 2'd2;
    localparam logic [1:0] CMD_READ_ROM  = 2'd3;

    // Addressing modes
    localparam logic [1:0] ADDR_MATCH0 = 2'd1;
    localparam logic [1:0] ADDR_MATCH1 = 2'd2;

    // Bus command bytes
    localparam logic [7:0] ROM_SKIP      = 8'hCC;
    localparam logic [7:0] ROM_MATCH     = 8'h55;
    localparam logic [7:0] ROM_READ      = 8'h33;
    localparam logic [7:0] FN_CONVERT    = 8'h44;
    localparam logic [7:0] FN_READ_PAD   = 8'hBE;
    localparam logic [7:0] FN_WRITE_PAD  = 8'h4E;
    localparam logic [7:0] RES_12BIT     = 8'h7F;

    // Configuration register indexes
    localparam logic [2:0] REG_SENSOR_ID_0   = 3'd0;
    localparam logic [2:0] REG_SENSOR_ID_1   = 3'd1;
    localparam logic [2:0] REG_RESOLUTION    = 3'd2;
    localparam logic [2:0] REG_RESET_PULSE   = 3'd3;
    localparam logic [2:0] REG_PRESENCE_SAMP = 3'd4;
    localparam logic [2:0] REG_WRITE_HOLD    = 3'd5;
    localparam logic [2:0] REG_READ_SAMPLE   = 3'd6;
    localparam logic [2:0] REG_READ_RECOVERY = 3'd7;

    // Sequencer phases
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_SAMP = 4'd2;
    localparam logic [3:0] PH_RST_END  = 4'd3;
    localparam logic [3:0] PH_W_LOW    = 4'd4;
    localparam logic [3:0] PH_W_HOLD   = 4'd5;
    localparam logic [3:0] PH_W_REC    = 4'd6;
    localparam logic [3:0] PH_R_LOW    = 4'd7;
    localparam logic [3:0] PH_R_WAIT   = 4'd8;
    localparam logic [3:0] PH_R_REC    = 4'd9;

    // Sequence operation kinds
    localparam logic [1:0] OP_END = 2'd0;
    localparam logic [1:0] OP_RST = 2'd1;
    localparam logic [1:0] OP_WR  = 2'd2;
    localparam logic [1:0] OP_RD  = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } owts_op_t;

    typedef struct packed {
        logic [63:0] sensor_id_0;
        logic [63:0] sensor_id_1;
        logic [7:0]  resolution_byte;
        logic [9:0]  reset_pulse_ticks;
        logic [7:0]  presence_sample_ticks;
        logic [6:0]  write_hold_ticks;
        logic [3:0]  read_sample_ticks;
        logic [6:0]  read_recovery_ticks;
    } owts_cfg_t;

    typedef struct packed {
        logic        line_drive;
        logic        busy_res;
        logic        done_res;
        logic        no_presence;
        logic [15:0] temperature;
        logic [63:0] rom_code;
    } owts_result_t;

    // A zero duration still lasts one tick
    function automatic logic [9:0] dur(input logic [9:0] v);
        return (v == 10'd0) ? 10'd1 : v;
    endfunction

    // Operation at a given step of the transaction
    function automatic owts_op_t op_at(
        input logic [4:0]  step,
        input logic [1:0]  cmd,
        input logic [1:0]  addr,
        input logic [63:0] id0,
        input logic [63:0] id1,
        input logic [7:0]  res
    );
        owts_op_t    op;
        logic        match;
        logic [63:0] id;
        logic [4:0]  base;
        logic [4:0]  rel;
        logic [2:0]  idx;
        op.kind = OP_END;
        op.data = 8'h00;
        match   = (addr == ADDR_MATCH0) || (addr == ADDR_MATCH1);
        id      = (addr == ADDR_MATCH0) ? id0 : id1;
        base    = match ? 5'd10 : 5'd2;
        rel     = step - base;
        idx     = 3'(step - 5'd2);
        if (step == 5'd0) begin
            op.kind = OP_RST;
        end else if (cmd == CMD_READ_ROM) begin
            if (step == 5'd1) begin
                op.kind = OP_WR;
                op.data = ROM_READ;
            end else if (step <= 5'd9) begin
                op.kind = OP_RD;
            end
        end else if (step == 5'd1) begin
            op.kind = OP_WR;
            op.data = match ? ROM_MATCH : ROM_SKIP;
        end else if (match && (step <= 5'd9)) begin
            op.kind = OP_WR;
            op.data = id[{idx, 3'b000} +: 8];
        end else begin
            case (cmd)
                CMD_CONVERT: begin
                    if (rel == 5'd0) begin
                        op.kind = OP_WR;
                        op.data = FN_CONVERT;
                    end
                end
                CMD_READ_TEMP: begin
                    if (rel == 5'd0) begin
                        op.kind = OP_WR;
                        op.data = FN_READ_PAD;
                    end else if ((rel == 5'd1) || (rel == 5'd2)) begin
                        op.kind = OP_RD;
                    end
                end
                default: begin
                    if (rel == 5'd0) begin
                        op.kind = OP_WR;
                        op.data = FN_WRITE_PAD;
                    end else if ((rel == 5'd1) || (rel == 5'd2)) begin
                        op.kind = OP_WR;
                    end else if (rel == 5'd3) begin
                        op.kind = OP_WR;
                        op.data = res;
                    end else if ((rel == 5'd4) && !match) begin
                        op.kind = OP_RST;  // skip-ROM config write closes with a reset
                    end
                end
            endcase
        end
        return op;
    endfunction

endpackage

@@ rtl/owts_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owts_if
// Valid/ready channels carrying the input items and the result items.
// ----------------------------------------------------------------------------
interface owts_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [1:0] command;
    logic [1:0] addressing;
    logic       line_in;

    modport source (output valid, kind, command, addressing, line_in, input ready);
    modport sink   (input valid, kind, command, addressing, line_in, output ready);
endinterface

interface owts_out_if;
    logic               valid;
    logic               ready;
    logic               line_drive;
    logic               busy_res;
    logic               done_res;
    logic               no_presence;
    logic signed [15:0] temperature;
    logic [63:0]        rom_code;

    modport source (output valid, line_drive, busy_res, done_res, no_presence,
                    temperature, rom_code, input ready);
    modport sink   (input valid, line_drive, busy_res, done_res, no_presence,
                    temperature, rom_code, output ready);
endinterface

@@ rtl/owts_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owts_cfg_regs
// Configuration register file: sensor ids, resolution byte and bus timing.
// ----------------------------------------------------------------------------
module owts_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [2:0]         wr_index,
    input  logic [63:0]        wr_data,
    output owts_pkg::owts_cfg_t cfg
);
    import owts_pkg::*;

    owts_cfg_t cfg_reg;

    // Register writes, each truncated to its field width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensor_id_0           <= 64'd0;
            cfg_reg.sensor_id_1           <= 64'd0;
            cfg_reg.resolution_byte       <= RES_12BIT;
            cfg_reg.reset_pulse_ticks     <= 10'd500;
            cfg_reg.presence_sample_ticks <= 8'd80;
            cfg_reg.write_hold_ticks      <= 7'd58;
            cfg_reg.read_sample_ticks     <= 4'd10;
            cfg_reg.read_recovery_ticks   <= 7'd50;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SENSOR_ID_0:   cfg_reg.sensor_id_0           <= wr_data;
                REG_SENSOR_ID_1:   cfg_reg.sensor_id_1           <= wr_data;
                REG_RESOLUTION:    cfg_reg.resolution_byte       <= wr_data[7:0];
                REG_RESET_PULSE:   cfg_reg.reset_pulse_ticks     <= wr_data[9:0];
                REG_PRESENCE_SAMP: cfg_reg.presence_sample_ticks <= wr_data[7:0];
                REG_WRITE_HOLD:    cfg_reg.write_hold_ticks      <= wr_data[6:0];
                REG_READ_SAMPLE:   cfg_reg.read_sample_ticks     <= wr_data[3:0];
                REG_READ_RECOVERY: cfg_reg.read_recovery_ticks   <= wr_data[6:0];
                default:           cfg_reg.sensor_id_0           <= cfg_reg.sensor_id_0;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/owts_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owts_core
// Bus sequencer: phase/slot timing, shift registers and held read results.
// ----------------------------------------------------------------------------
module owts_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   kind,
    input  logic [1:0]             command,
    input  logic [1:0]             addressing,
    input  logic                   line_in,
    input  owts_pkg::owts_cfg_t    cfg,
    output owts_pkg::owts_result_t result
);
    import owts_pkg::*;

    logic [3:0]  phase_reg,     phase_next;
    logic [4:0]  step_reg,      step_next;
    logic [9:0]  tick_reg,      tick_next;
    logic [2:0]  bit_reg,       bit_next;
    logic [7:0]  tx_reg,        tx_next;
    logic [63:0] rx_reg,        rx_next;
    logic [1:0]  cmd_reg,       cmd_next;
    logic [1:0]  addr_reg,      addr_next;
    logic        presence_reg,  presence_next;
    logic [15:0] temp_reg,      temp_next;
    logic [63:0] rom_reg,       rom_next;

    logic        drive;
    logic        done;
    logic        do_adv;
    logic [9:0]  limit;
    logic [9:0]  tick_inc;
    logic [4:0]  step_inc;
    owts_op_t    adv_op;

    // Next operation in the sequence
    assign step_inc = step_reg + 5'd1;
    assign adv_op   = op_at(step_inc, cmd_reg, addr_reg, cfg.sensor_id_0,
                            cfg.sensor_id_1, cfg.resolution_byte);
    assign tick_inc = tick_reg + 10'd1;

    // Phase duration and drive level for a tick
    always_comb
    begin
        drive = 1'b1;
        case (phase_reg)
            PH_RST_LOW:
            begin
                drive = 1'b0;
                limit = dur(cfg.reset_pulse_ticks);
            end
            PH_RST_SAMP: limit = dur({2'b00, cfg.presence_sample_ticks});
            PH_RST_END:  limit = dur(cfg.reset_pulse_ticks);
            PH_W_LOW:
            begin
                drive = 1'b0;
                limit = START_LOW_TICKS;
            end
            PH_W_HOLD:
            begin
                drive = tx_reg[0];
                limit = dur({3'b000, cfg.write_hold_ticks});
            end
            PH_W_REC:    limit = 10'd1;
            PH_R_LOW:
            begin
                drive = 1'b0;
                limit = START_LOW_TICKS;
            end
            PH_R_WAIT:   limit = dur({6'd0, cfg.read_sample_ticks});
            default:     limit = dur({3'b000, cfg.read_recovery_ticks});
        endcase
        if ((phase_reg == PH_IDLE) || (kind == KIND_START))
        begin
            drive = 1'b1;
        end
    end

    // Next state for one item
    always_comb
    begin
        phase_next    = phase_reg;
        step_next     = step_reg;
        tick_next     = tick_reg;
        bit_next      = bit_reg;
        tx_next       = tx_reg;
        rx_next       = rx_reg;
        cmd_next      = cmd_reg;
        addr_next     = addr_reg;
        presence_next = presence_reg;
        temp_next     = temp_reg;
        rom_next      = rom_reg;
        done          = 1'b0;
        do_adv        = 1'b0;

        if (kind == KIND_START)
        begin
            // start is taken only while idle; step 0 is always a reset
            if (phase_reg == PH_IDLE)
            begin
                cmd_next   = command;
                addr_next  = addressing;
                step_next  = 5'd0;
                rx_next    = 64'd0;
                tick_next  = 10'd0;
                bit_next   = 3'd0;
                phase_next = PH_RST_LOW;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            tick_next = tick_inc;
            if (tick_inc >= limit)
            begin
                tick_next = 10'd0;
                case (phase_reg)
                    PH_RST_LOW:  phase_next = PH_RST_SAMP;
                    PH_RST_SAMP:
                    begin
                        presence_next = line_in;
                        phase_next    = PH_RST_END;
                    end
                    PH_RST_END:  do_adv = 1'b1;
                    PH_W_LOW:    phase_next = PH_W_HOLD;
                    PH_W_HOLD:   phase_next = PH_W_REC;
                    PH_W_REC:
                    begin
                        tx_next  = {1'b0, tx_reg[7:1]};
                        bit_next = bit_reg + 3'd1;
                        if (bit_reg == 3'd7)
                        begin
                            do_adv = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_W_LOW;
                        end
                    end
                    PH_R_LOW:    phase_next = PH_R_WAIT;
                    PH_R_WAIT:
                    begin
                        rx_next    = {line_in, rx_reg[63:1]};
                        phase_next = PH_R_REC;
                    end
                    default:
                    begin
                        bit_next = bit_reg + 3'd1;
                        if (bit_reg == 3'd7)
                        begin
                            do_adv = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_R_LOW;
                        end
                    end
                endcase
            end
        end

        // Load the next operation, or finish the transaction
        if (do_adv)
        begin
            step_next = step_inc;
            tick_next = 10'd0;
            bit_next  = 3'd0;
            case (adv_op.kind)
                OP_RST: phase_next = PH_RST_LOW;
                OP_WR:
                begin
                    tx_next    = adv_op.data;
                    phase_next = PH_W_LOW;
                end
                OP_RD:  phase_next = PH_R_LOW;
                default:
                begin
                    if (cmd_reg == CMD_READ_TEMP)
                    begin
                        temp_next = rx_next[63:48];
                    end
                    if (cmd_reg == CMD_READ_ROM)
                    begin
                        rom_next = rx_next;
                    end
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            step_reg     <= 5'd0;
            tick_reg     <= 10'd0;
            bit_reg      <= 3'd0;
            tx_reg       <= 8'd0;
            rx_reg       <= 64'd0;
            cmd_reg      <= 2'd0;
            addr_reg     <= 2'd0;
            presence_reg <= 1'b0;
            temp_reg     <= 16'd0;
            rom_reg      <= 64'd0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            step_reg     <= step_next;
            tick_reg     <= tick_next;
            bit_reg      <= bit_next;
            tx_reg       <= tx_next;
            rx_reg       <= rx_next;
            cmd_reg      <= cmd_next;
            addr_reg     <= addr_next;
            presence_reg <= presence_next;
            temp_reg     <= temp_next;
            rom_reg      <= rom_next;
        end
    end

    // Result of this item
    always_comb
    begin
        result.line_drive  = drive;
        result.busy_res    = (phase_next != PH_IDLE);
        result.done_res    = done;
        result.no_presence = presence_next;
        result.temperature = temp_next;
        result.rom_code    = rom_next;
    end

    // Idle sequencer always holds a cleared tick counter
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (tick_reg == 10'd0))
        else $error("tick counter not cleared while idle");

    // A start seen while idle opens with a reset pulse
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_START) && (phase_reg == PH_IDLE))
        |=> (phase_reg == PH_RST_LOW) && (step_reg == 5'd0))
        else $error("start did not open with a reset");

    // A finishing item leaves the sequencer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && done) |=> (phase_reg == PH_IDLE))
        else $error("transaction finished but sequencer still busy");

endmodule

@@ rtl/owts_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owts_out_stage
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module owts_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  owts_pkg::owts_result_t result,
    output logic                   slot_free,
    owts_out_if.source             out_ch
);
    import owts_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    owts_result_t data_reg;

    // Free when empty or being drained this cycle
    assign slot_free  = !valid_reg || out_ch.ready;
    assign valid_next = load | (valid_reg & !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.line_drive  = data_reg.line_drive;
    assign out_ch.busy_res    = data_reg.busy_res;
    assign out_ch.done_res    = data_reg.done_res;
    assign out_ch.no_presence = data_reg.no_presence;
    assign out_ch.temperature = data_reg.temperature;
    assign out_ch.rom_code    = data_reg.rom_code;

    // Loads only happen into a free slot
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> slot_free)
        else $error("result loaded over an untaken item");

endmodule

@@ rtl/onewire_temperature_sensor_master.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_temperature_sensor_master
// 1-Wire bus master for a temperature sensor, paced by microsecond tick items.
// ----------------------------------------------------------------------------
// Every input item (a tick or a start request) produces exactly one result
// item, which appears in the cycle after it is accepted. The block takes one item per clock:
// in_ch.ready is high whenever the result register is empty or is being read
// in the same cycle, so the rate is set only by the single result register
// and the consumer's ready. Bus timing counts ticks, not clocks. Temperature
// is the raw signed Q12.4 value (divide by 16 for degrees); temperature and
// rom_code always show the values from the last completed read.
module onewire_temperature_sensor_master (
    input  logic        clk,
    input  logic        rst_n,
    owts_in_if.sink     in_ch,
    owts_out_if.source  out_ch,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [63:0] wr_data
);
    import owts_pkg::*;

    owts_cfg_t    cfg;
    owts_result_t result;
    logic         slot_free;
    logic         accept;

    assign in_ch.ready = slot_free;
    assign accept      = in_ch.valid & slot_free;

    // Configuration registers
    owts_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // Bus sequencer
    owts_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .kind       (in_ch.kind),
        .command    (in_ch.command),
        .addressing (in_ch.addressing),
        .line_in    (in_ch.line_in),
        .cfg        (cfg),
        .result     (result)
    );

    // Result register
    owts_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .result    (result),
        .slot_free (slot_free),
        .out_ch    (out_ch)
    );

endmodule

@@ tb/owts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owts_checker
// Watches the item and result channels of the 1-Wire master and the register
// write port. It runs its own model of the bus sequencer on every accepted
// item and compares each accepted result with the oldest predicted one.
// ----------------------------------------------------------------------------
module owts_checker (
    input  logic        clk,
    input  logic        rst_n,
    owts_in_if          in_mon,
    owts_out_if         out_mon,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [63:0] wr_data,
    output int unsigned mismatch_total,
    output int unsigned outstanding
);
    import owts_pkg::*;

    localparam int unsigned MAX_REPORTS = 10;

    // register copy and sequencer state
    owts_cfg_t    regs;
    logic [3:0]   seq_phase;
    logic [4:0]   seq_step;
    int           slot_ticks;
    logic [2:0]   bit_idx;
    logic [7:0]   tx_byte;
    logic [63:0]  rx_bits;
    logic [1:0]   cur_cmd;
    logic [1:0]   cur_addr;
    logic         presence_missing;
    logic [15:0]  last_temp;
    logic [63:0]  last_rom;

    owts_result_t expected_results [$];
    owts_result_t predicted;
    owts_result_t got;
    owts_result_t want;
    int unsigned  result_index;
    int unsigned  mismatches;

    // bus operation at a given position of the current transaction
    function automatic owts_op_t bus_op(input logic [4:0] step);
        owts_op_t    plan [$];
        logic        matched;
        logic [63:0] rom_id;
        matched = (cur_addr == ADDR_MATCH0) || (cur_addr == ADDR_MATCH1);
        rom_id  = (cur_addr == ADDR_MATCH0) ? regs.sensor_id_0 : regs.sensor_id_1;
        plan.push_back({OP_RST, 8'h00});
        if (cur_cmd == CMD_READ_ROM)
        begin
            plan.push_back({OP_WR, ROM_READ});
            repeat (8) plan.push_back({OP_RD, 8'h00});
        end
        else
        begin
            if (matched)
            begin
                plan.push_back({OP_WR, ROM_MATCH});
                for (int b = 0; b < 8; b++)
                    plan.push_back({OP_WR, rom_id[8*b +: 8]});
            end
            else
                plan.push_back({OP_WR, ROM_SKIP});
            case (cur_cmd)
                CMD_CONVERT:
                    plan.push_back({OP_WR, FN_CONVERT});
                CMD_READ_TEMP:
                begin
                    plan.push_back({OP_WR, FN_READ_PAD});
                    plan.push_back({OP_RD, 8'h00});
                    plan.push_back({OP_RD, 8'h00});
                end
                default:
                begin
                    plan.push_back({OP_WR, FN_WRITE_PAD});
                    plan.push_back({OP_WR, 8'h00});
                    plan.push_back({OP_WR, 8'h00});
                    plan.push_back({OP_WR, regs.resolution_byte});
                    // skip-ROM form closes with one more reset
                    if (!matched)
                        plan.push_back({OP_RST, 8'h00});
                end
            endcase
        end
        if (step < plan.size())
            return plan[step];
        return {OP_END, 8'h00};
    endfunction

    // zero in a timing register still means one tick
    function automatic int at_least_one(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    // load the operation at seq_step; returns 1 when the transaction is over
    function automatic logic enter_op();
        owts_op_t op;
        op         = bus_op(seq_step);
        slot_ticks = 0;
        bit_idx    = '0;
        enter_op   = 1'b0;
        case (op.kind)
            OP_RST:
                seq_phase = PH_RST_LOW;
            OP_WR:
            begin
                tx_byte   = op.data;
                seq_phase = PH_W_LOW;
            end
            OP_RD:
                seq_phase = PH_R_LOW;
            default:
            begin
                if (cur_cmd == CMD_READ_TEMP)
                    last_temp = rx_bits[63:48];
                if (cur_cmd == CMD_READ_ROM)
                    last_rom = rx_bits;
                seq_phase = PH_IDLE;
                enter_op  = 1'b1;
            end
        endcase
    endfunction

    function automatic logic next_op();
        seq_step = seq_step + 5'd1;
        return enter_op();
    endfunction

    // advance the model by one item and form the result it produces
    task automatic predict_item(input logic kind, input logic [1:0] cmd,
                                input logic [1:0] addr, input logic line,
                                output owts_result_t res);
        logic drive;
        logic finished;
        int   limit;
        drive    = 1'b1;
        finished = 1'b0;
        limit    = 1;
        if (kind == KIND_START)
        begin
            // a start is taken only while idle
            if (seq_phase == PH_IDLE)
            begin
                cur_cmd  = cmd;
                cur_addr = addr;
                seq_step = '0;
                rx_bits  = '0;
                void'(enter_op());
            end
        end
        else if (seq_phase != PH_IDLE)
        begin
            case (seq_phase)
                PH_RST_LOW:
                begin
                    drive = 1'b0;
                    limit = at_least_one(int'(regs.reset_pulse_ticks));
                end
                PH_RST_SAMP: limit = at_least_one(int'(regs.presence_sample_ticks));
                PH_RST_END:  limit = at_least_one(int'(regs.reset_pulse_ticks));
                PH_W_LOW:
                begin
                    drive = 1'b0;
                    limit = int'(START_LOW_TICKS);
                end
                PH_W_HOLD:
                begin
                    drive = tx_byte[0];
                    limit = at_least_one(int'(regs.write_hold_ticks));
                end
                PH_W_REC:    limit = 1;
                PH_R_LOW:
                begin
                    drive = 1'b0;
                    limit = int'(START_LOW_TICKS);
                end
                PH_R_WAIT:   limit = at_least_one(int'(regs.read_sample_ticks));
                default:     limit = at_least_one(int'(regs.read_recovery_ticks));
            endcase
            slot_ticks = slot_ticks + 1;
            if (slot_ticks >= limit)
            begin
                slot_ticks = 0;
                case (seq_phase)
                    PH_RST_LOW:  seq_phase = PH_RST_SAMP;
                    PH_RST_SAMP:
                    begin
                        // high line at the sample means nobody answered
                        presence_missing = line;
                        seq_phase        = PH_RST_END;
                    end
                    PH_RST_END:  finished = next_op();
                    PH_W_LOW:    seq_phase = PH_W_HOLD;
                    PH_W_HOLD:   seq_phase = PH_W_REC;
                    PH_W_REC:
                    begin
                        tx_byte = tx_byte >> 1;
                        bit_idx = bit_idx + 3'd1;
                        if (bit_idx == 3'd0)
                            finished = next_op();
                        else
                            seq_phase = PH_W_LOW;
                    end
                    PH_R_LOW:    seq_phase = PH_R_WAIT;
                    PH_R_WAIT:
                    begin
                        // bits arrive LSB first, shifted in from the top
                        rx_bits   = {line, rx_bits[63:1]};
                        seq_phase = PH_R_REC;
                    end
                    default:
                    begin
                        bit_idx = bit_idx + 3'd1;
                        if (bit_idx == 3'd0)
                            finished = next_op();
                        else
                            seq_phase = PH_R_LOW;
                    end
                endcase
            end
        end
        res.line_drive  = drive;
        res.busy_res    = (seq_phase != PH_IDLE);
        res.done_res    = finished;
        res.no_presence = presence_missing;
        res.temperature = last_temp;
        res.rom_code    = last_rom;
    endtask

    // register writes, result check, then prediction of the new item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.sensor_id_0           = '0;
            regs.sensor_id_1           = '0;
            regs.resolution_byte       = RES_12BIT;
            regs.reset_pulse_ticks     = 10'd500;
            regs.presence_sample_ticks = 8'd80;
            regs.write_hold_ticks      = 7'd58;
            regs.read_sample_ticks     = 4'd10;
            regs.read_recovery_ticks   = 7'd50;
            seq_phase        = PH_IDLE;
            seq_step         = '0;
            slot_ticks       = 0;
            bit_idx          = '0;
            tx_byte          = '0;
            rx_bits          = '0;
            cur_cmd          = CMD_CONVERT;
            cur_addr         = '0;
            presence_missing = 1'b0;
            last_temp        = '0;
            last_rom         = '0;
            expected_results.delete();
            result_index     = 0;
            mismatches       = 0;
            mismatch_total  <= 0;
            outstanding     <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_SENSOR_ID_0:   regs.sensor_id_0           = wr_data;
                    REG_SENSOR_ID_1:   regs.sensor_id_1           = wr_data;
                    REG_RESOLUTION:    regs.resolution_byte       = wr_data[7:0];
                    REG_RESET_PULSE:   regs.reset_pulse_ticks     = wr_data[9:0];
                    REG_PRESENCE_SAMP: regs.presence_sample_ticks = wr_data[7:0];
                    REG_WRITE_HOLD:    regs.write_hold_ticks      = wr_data[6:0];
                    REG_READ_SAMPLE:   regs.read_sample_ticks     = wr_data[3:0];
                    REG_READ_RECOVERY: regs.read_recovery_ticks   = wr_data[6:0];
                    default: ;
                endcase
            end

            if (out_mon.valid && out_mon.ready)
            begin
                got.line_drive  = out_mon.line_drive;
                got.busy_res    = out_mon.busy_res;
                got.done_res    = out_mon.done_res;
                got.no_presence = out_mon.no_presence;
                got.temperature = out_mon.temperature;
                got.rom_code    = out_mon.rom_code;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d arrived with nothing expected", result_index);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("result %0d mismatch at %0t", result_index, $realtime);
                            $display("  expected drive %b busy %b done %b absent %b temp %h rom %h",
                                     want.line_drive, want.busy_res, want.done_res,
                                     want.no_presence, want.temperature, want.rom_code);
                            $display("  actual   drive %b busy %b done %b absent %b temp %h rom %h",
                                     got.line_drive, got.busy_res, got.done_res,
                                     got.no_presence, got.temperature, got.rom_code);
                        end
                    end
                end
                result_index++;
            end

            if (in_mon.valid && in_mon.ready)
            begin
                predict_item(in_mon.kind, in_mon.command, in_mon.addressing,
                             in_mon.line_in, predicted);
                expected_results.push_back(predicted);
            end

            mismatch_total <= mismatches;
            outstanding    <= expected_results.size();
        end
    end

endmodule

@@ tb/onewire_temperature_sensor_master_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_temperature_sensor_master_tb
// Drives tick and start items into the 1-Wire master, loads the timing and id
// registers between transactions, and applies random stalls on both channels.
// Checking is done by owts_checker; this module reports the verdict.
// ----------------------------------------------------------------------------
module onewire_temperature_sensor_master_tb;
    import owts_pkg::*;

    localparam int          CLK_HALF       = 6;
    localparam int          RESET_CYCLES   = 6;
    localparam int unsigned CYCLE_LIMIT    = 2_000_000;
    localparam int unsigned RANDOM_TXNS    = 1;
    localparam int          SQUEEZE_CYCLES = 400;
    localparam int          DRAIN_CYCLES   = 8;

    // addressing codes not named in the package
    localparam logic [1:0] ADDR_SKIP  = 2'd0;
    localparam logic [1:0] ADDR_ALIAS = 2'd3;

    // line_in pattern during one transaction
    typedef enum logic [1:0] {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_pattern_t;

    logic        clk;
    logic        rst_n;
    logic        wr_en;
    logic [2:0]  wr_index;
    logic [63:0] wr_data;

    owts_in_if  in_ch ();
    owts_out_if out_ch ();

    int unsigned mismatch_total;
    int unsigned outstanding;
    int unsigned send_gap_pct;
    int unsigned recv_gap_pct;
    logic        squeeze_req;
    logic        out_hold;
    int unsigned cycle_count;
    int unsigned busy_items;
    int unsigned settings_loaded;
    int unsigned txn_done_count;
    int unsigned absent_count;
    int unsigned cmd_count [4];

    onewire_temperature_sensor_master dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    owts_checker result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_mon         (in_ch),
        .out_mon        (out_ch),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .mismatch_total (mismatch_total),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("[FAIL] regression broken");
        $finish;
    end

    // result consumer with random back-pressure
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= !out_hold && ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // one long hold-off on the result side so the block fills and stalls
    initial
    begin
        out_hold <= 1'b0;
        wait (squeeze_req == 1'b1);
        @(posedge clk);
        out_hold <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        out_hold <= 1'b0;
    end

    // finished transactions, as seen on the result channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            txn_done_count <= 0;
            absent_count   <= 0;
        end
        else if (out_ch.valid && out_ch.ready && out_ch.done_res)
        begin
            txn_done_count <= txn_done_count + 1;
            if (out_ch.no_presence)
                absent_count <= absent_count + 1;
        end
    end

    // offer one item, with a random gap first, and wait until it is taken
    task automatic send_item(input logic kind, input logic [1:0] cmd,
                             input logic [1:0] addr, input logic line);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.command    <= cmd;
        in_ch.addressing <= addr;
        in_ch.line_in    <= line;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
    endtask

    function automatic owts_cfg_t make_settings(
        input logic [63:0] id0,
        input logic [63:0] id1,
        input logic [7:0]  resolution,
        input logic [9:0]  reset_pulse,
        input logic [7:0]  presence_sample,
        input logic [6:0]  write_hold,
        input logic [3:0]  read_sample,
        input logic [6:0]  read_recovery
    );
        owts_cfg_t s;
        s.sensor_id_0           = id0;
        s.sensor_id_1           = id1;
        s.resolution_byte       = resolution;
        s.reset_pulse_ticks     = reset_pulse;
        s.presence_sample_ticks = presence_sample;
        s.write_hold_ticks      = write_hold;
        s.read_sample_ticks     = read_sample;
        s.read_recovery_ticks   = read_recovery;
        return s;
    endfunction

    // drain all results, then write every register
    task automatic load_settings(input owts_cfg_t s);
        logic [63:0] vals [8];
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        vals[REG_SENSOR_ID_0]   = s.sensor_id_0;
        vals[REG_SENSOR_ID_1]   = s.sensor_id_1;
        vals[REG_RESOLUTION]    = 64'(s.resolution_byte);
        vals[REG_RESET_PULSE]   = 64'(s.reset_pulse_ticks);
        vals[REG_PRESENCE_SAMP] = 64'(s.presence_sample_ticks);
        vals[REG_WRITE_HOLD]    = 64'(s.write_hold_ticks);
        vals[REG_READ_SAMPLE]   = 64'(s.read_sample_ticks);
        vals[REG_READ_RECOVERY] = 64'(s.read_recovery_ticks);
        for (int r = 0; r < 8; r++)
        begin
            wr_en    <= 1'b1;
            wr_index <= 3'(r);
            wr_data  <= vals[r];
            @(posedge clk);
        end
        wr_en <= 1'b0;
        settings_loaded++;
    endtask

    // one whole transaction: a start, then ticks until its done is seen
    task automatic run_txn(input logic [1:0] cmd, input logic [1:0] addr,
                           input line_pattern_t pattern, input bit with_noise);
        int unsigned done_mark;
        logic        level;
        done_mark = txn_done_count;
        send_item(KIND_START, cmd, addr, 1'($urandom_range(1)));
        busy_items++;
        cmd_count[cmd]++;
        // a second start during the opening reset must be ignored
        if (with_noise)
            send_item(KIND_START, 2'($urandom_range(3)), 2'($urandom_range(3)), 1'b1);
        while (txn_done_count == done_mark)
        begin
            case (pattern)
                LINE_LOW:  level = 1'b0;
                LINE_HIGH: level = 1'b1;
                default:   level = 1'($urandom_range(1));
            endcase
            send_item(KIND_TICK, 2'($urandom_range(3)), 2'($urandom_range(3)), level);
            busy_items++;
        end
    endtask

    // random transactions with short timings, settings changed every two
    task automatic random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                input int unsigned txn_total, input bit squeeze);
        int unsigned   txns;
        int unsigned   pick;
        line_pattern_t pattern;
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
        txns         = 0;
        if (squeeze)
            squeeze_req <= 1'b1;
        while (txns < txn_total)
        begin
            if (txns % 2 == 0)
                load_settings(make_settings({$urandom, $urandom}, {$urandom, $urandom},
                                            8'($urandom), 10'($urandom_range(3)),
                                            8'($urandom_range(3)), 7'($urandom_range(3)),
                                            4'($urandom_range(3)), 7'($urandom_range(3))));
            // stray ticks while idle
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(3, 1))
                    send_item(KIND_TICK, 2'($urandom_range(3)), 2'($urandom_range(3)),
                              1'($urandom_range(1)));
            pick = $urandom_range(9);
            if (pick < 3)
                pattern = LINE_LOW;
            else if (pick == 3)
                pattern = LINE_HIGH;
            else
                pattern = LINE_RANDOM;
            run_txn(2'($urandom_range(3)), 2'($urandom_range(3)), pattern,
                    $urandom_range(4) == 0);
            txns++;
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        wr_en            <= 1'b0;
        wr_index         <= REG_SENSOR_ID_0;
        wr_data          <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= KIND_TICK;
        in_ch.command    <= CMD_CONVERT;
        in_ch.addressing <= ADDR_SKIP;
        in_ch.line_in    <= 1'b1;
        squeeze_req      <= 1'b0;
        send_gap_pct     = 21;
        recv_gap_pct     = 85;
        busy_items       = 0;
        settings_loaded  = 0;
        foreach (cmd_count[c])
            cmd_count[c] = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ticks while idle under reset settings, both line levels
        send_item(KIND_TICK, CMD_READ_ROM, ADDR_ALIAS, 1'b1);
        send_item(KIND_TICK, CMD_CONVERT, ADDR_SKIP, 1'b0);

        // all timing registers zero: each phase but the slot-opening low lasts one tick
        load_settings(make_settings('1, '0, 8'hFF, '0, '0, '0, '0, '0));
        run_txn(CMD_CONVERT, ADDR_SKIP, LINE_HIGH, 1'b1);
        run_txn(CMD_READ_TEMP, ADDR_MATCH0, LINE_RANDOM, 1'b0);

        // sender mostly idle, receiver mostly ready
        send_gap_pct = 85;
        recv_gap_pct = 21;
        run_txn(CMD_WRITE_CFG, ADDR_SKIP, LINE_RANDOM, 1'b1);
        run_txn(CMD_READ_ROM, ADDR_ALIAS, LINE_RANDOM, 1'b0);

        // no idling, with one long result hold-off
        random_phase(0, 0, RANDOM_TXNS, 1'b1);

        // wait for the last results
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d busy items, %0d transactions (%0d without presence), %0d settings",
                 busy_items, txn_done_count, absent_count, settings_loaded);
        $display("starts: convert %0d, read temp %0d, write config %0d, read rom %0d",
                 cmd_count[CMD_CONVERT], cmd_count[CMD_READ_TEMP],
                 cmd_count[CMD_WRITE_CFG], cmd_count[CMD_READ_ROM]);
        if (mismatch_total == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
